>>> rtl/csma_cd_backoff_controller_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CSMA_CD_BACKOFF_CONTROLLER_TOP_ASSERT_SVH
`define CSMA_CD_BACKOFF_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSMACD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csmacd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CSMACD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csmacd assertion failed");

`endif

>>> rtl/csmacd_pkg.sv
`timescale 1ns / 1ps

package csmacd_pkg;

	typedef enum logic [1:0] {
		MODE_SENSE   = 2'd0,
		MODE_TX      = 2'd1,
		MODE_BACKOFF = 2'd2
	} mode_t;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SENSING   = 3'd1;
	localparam logic [2:0] ST_TX        = 3'd2;
	localparam logic [2:0] ST_COMPLETED = 3'd3;
	localparam logic [2:0] ST_BACKOFF   = 3'd4;
	localparam logic [2:0] ST_DROPPED   = 3'd5;

	localparam logic [1:0] REG_SENSE_TICKS   = 2'd0;
	localparam logic [1:0] REG_SLOT_TICKS    = 2'd1;
	localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd2;
	localparam logic [1:0] REG_BACKOFF_CAP   = 2'd3;

	localparam logic [15:0] SENSE_TICKS_RST   = 16'd2;
	localparam logic [15:0] SLOT_TICKS_RST    = 16'd2;
	localparam logic [4:0]  ATTEMPT_LIMIT_RST = 5'd16;
	localparam logic [3:0]  BACKOFF_CAP_RST   = 4'd10;

endpackage

>>> rtl/csma_cd_backoff_controller_top.sv
`timescale 1ns / 1ps

// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | frame_pending medium_busy collision tx_done random_value
// output  | out_valid | out_stall | status transmit_enable attempt_count backoff_slots
//         |           |           | frame_number
// config  | cfg_we    | -         | cfg_index cfg_data
//
// One item per cycle sustained while the result is not stalled; each item passes through
// the input register and then the result register.
// The input register feeds the controller logic, which updates state and loads the
// result register together.
// Reset (arst_n low) clears state to sensing with all counters zero and registers to defaults.
// A stalled result holds; the input register keeps accepting while the result register
// is free or being drained.
module csma_cd_backoff_controller_top
	import csmacd_pkg::*;
#(
	parameter int MAX_EXPONENT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        frame_pending,
	input  logic        medium_busy,
	input  logic        collision,
	input  logic        tx_done,
	input  logic [9:0]  random_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        transmit_enable,
	output logic [4:0]  attempt_count,
	output logic [9:0]  backoff_slots,
	output logic [15:0] frame_number
);

	localparam logic [4:0] MAX_EXP = 5'(MAX_EXPONENT);

	// configuration
	logic [15:0] sense_ticks_q;
	logic [15:0] slot_ticks_q;
	logic [4:0]  attempt_limit_q;
	logic [3:0]  backoff_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_ticks_q   <= SENSE_TICKS_RST;
			slot_ticks_q    <= SLOT_TICKS_RST;
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
			backoff_cap_q   <= BACKOFF_CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSE_TICKS:   sense_ticks_q   <= cfg_data;
				REG_SLOT_TICKS:    slot_ticks_q    <= cfg_data;
				REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data[4:0];
				REG_BACKOFF_CAP:   backoff_cap_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       pending_s1, busy_s1, coll_s1, done_s1;
	logic [9:0] rnd_s1;
	logic       adv;
	logic       in_xfer;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pending_s1 <= frame_pending;
			busy_s1    <= medium_busy;
			coll_s1    <= collision;
			done_s1    <= tx_done;
			rnd_s1     <= random_value;
		end
	end

	// controller state
	mode_t       mode_q, mode_d;
	logic [15:0] idle_run_q, idle_run_d;
	logic [4:0]  attempts_q, attempts_d;
	logic [9:0]  slots_left_q, slots_left_d;
	logic [15:0] slot_tick_q, slot_tick_d;
	logic [15:0] frame_count_q, frame_count_d;
	logic [9:0]  last_draw_q, last_draw_d;

	// shared terms
	logic [5:0]  n_sum;
	logic [4:0]  n_att;
	logic        drop;
	logic [15:0] idle_inc;
	logic [15:0] need_idle;
	logic [15:0] slot_len;
	logic        start_tx;
	logic [4:0]  cap_eff;
	logic [4:0]  exp_sel;
	logic [16:0] mask;
	logic [16:0] tick_sum;

	always_comb begin
		n_sum     = {1'b0, attempts_q} + 6'd1;
		n_att     = n_sum[5] ? 5'd31 : n_sum[4:0];
		drop      = n_att >= attempt_limit_q;
		idle_inc  = busy_s1 ? 16'd0 :
			((idle_run_q != 16'hFFFF) ? idle_run_q + 16'd1 : idle_run_q);
		need_idle = (sense_ticks_q == 16'd0) ? 16'd1 : sense_ticks_q;
		slot_len  = (slot_ticks_q == 16'd0) ? 16'd1 : slot_ticks_q;
		start_tx  = idle_inc >= need_idle;
		cap_eff   = ({1'b0, backoff_cap_q} > MAX_EXP) ? MAX_EXP : {1'b0, backoff_cap_q};
		exp_sel   = (n_att > cap_eff) ? cap_eff : n_att;
		mask      = (17'd1 << exp_sel) - 17'd1;
		tick_sum  = {1'b0, slot_tick_q} + 17'd1;
	end

	// next state
	always_comb begin
		mode_d        = mode_q;
		idle_run_d    = idle_run_q;
		attempts_d    = attempts_q;
		slots_left_d  = slots_left_q;
		slot_tick_d   = slot_tick_q;
		frame_count_d = frame_count_q;
		last_draw_d   = last_draw_q;
		unique case (mode_q)
			MODE_TX: begin
				if (coll_s1) begin
					if (drop) begin
						attempts_d    = 5'd0;
						frame_count_d = frame_count_q + 16'd1;
						mode_d        = MODE_SENSE;
						idle_run_d    = 16'd0;
					end else begin
						attempts_d   = n_att;
						last_draw_d  = rnd_s1 & mask[9:0];
						slots_left_d = rnd_s1 & mask[9:0];
						slot_tick_d  = 16'd0;
						mode_d       = MODE_BACKOFF;
					end
				end else if (done_s1) begin
					attempts_d    = 5'd0;
					frame_count_d = frame_count_q + 16'd1;
					mode_d        = MODE_SENSE;
					idle_run_d    = 16'd0;
				end
			end
			MODE_BACKOFF: begin
				if (slots_left_q == 10'd0) begin
					mode_d     = MODE_SENSE;
					idle_run_d = 16'd0;
				end else if (tick_sum >= {1'b0, slot_len}) begin
					slot_tick_d  = 16'd0;
					slots_left_d = slots_left_q - 10'd1;
				end else begin
					slot_tick_d = tick_sum[15:0];
				end
			end
			default: begin
				// sensing; the unused code behaves the same
				mode_d = MODE_SENSE;
				if (!pending_s1) begin
					idle_run_d = 16'd0;
				end else if (start_tx) begin
					mode_d     = MODE_TX;
					idle_run_d = 16'd0;
				end else begin
					idle_run_d = idle_inc;
				end
			end
		endcase
	end

	// result fields
	logic [2:0] status_d;
	logic       tx_en_d;
	logic [4:0] shown_att_d;

	always_comb begin
		status_d    = ST_IDLE;
		tx_en_d     = 1'b0;
		shown_att_d = attempts_q;
		unique case (mode_q)
			MODE_TX: begin
				if (coll_s1) begin
					status_d    = drop ? ST_DROPPED : ST_BACKOFF;
					shown_att_d = n_att;
				end else if (done_s1) begin
					status_d    = ST_COMPLETED;
					shown_att_d = 5'd0;
				end else begin
					status_d = ST_TX;
					tx_en_d  = 1'b1;
				end
			end
			MODE_BACKOFF: begin
				status_d = ST_BACKOFF;
			end
			default: begin
				if (!pending_s1) begin
					status_d = ST_IDLE;
				end else if (start_tx) begin
					status_d = ST_TX;
					tx_en_d  = 1'b1;
				end else begin
					status_d = ST_SENSING;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_SENSE;
			idle_run_q    <= 16'd0;
			attempts_q    <= 5'd0;
			slots_left_q  <= 10'd0;
			slot_tick_q   <= 16'd0;
			frame_count_q <= 16'd0;
			last_draw_q   <= 10'd0;
		end else if (adv) begin
			mode_q        <= mode_d;
			idle_run_q    <= idle_run_d;
			attempts_q    <= attempts_d;
			slots_left_q  <= slots_left_d;
			slot_tick_q   <= slot_tick_d;
			frame_count_q <= frame_count_d;
			last_draw_q   <= last_draw_d;
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv || (out_valid_q && out_stall);
		end
	end

	logic [2:0]  status_q;
	logic        tx_en_q;
	logic [4:0]  shown_att_q;
	logic [9:0]  slots_out_q;
	logic [15:0] frame_out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q    <= status_d;
			tx_en_q     <= tx_en_d;
			shown_att_q <= shown_att_d;
			slots_out_q <= last_draw_d;
			frame_out_q <= frame_count_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign transmit_enable = tx_en_q;
	assign attempt_count   = shown_att_q;
	assign backoff_slots   = slots_out_q;
	assign frame_number    = frame_out_q;

endmodule

>>> rtl/csmacd_checker.sv
`timescale 1ns / 1ps

`include "csma_cd_backoff_controller_top_assert.svh"

module csmacd_checker
	import csmacd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        transmit_enable,
	input logic [4:0]  attempt_count,
	input logic [9:0]  backoff_slots,
	input logic [15:0] frame_number
);

	// a stalled result stays put
	`CSMACD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(attempt_count) && $stable(backoff_slots) && $stable(frame_number) && $stable(transmit_enable))

	// the station drives the medium only while reporting transmission
	`CSMACD_ASSERT_NOW(a_tx_en_status, out_valid && transmit_enable, status == ST_TX)

	// a drop always follows at least one collision
	`CSMACD_ASSERT_NOW(a_drop_count, out_valid && status == ST_DROPPED, attempt_count != 5'd0)

	// a completed frame reports a cleared count
	`CSMACD_ASSERT_NOW(a_done_count, out_valid && status == ST_COMPLETED, attempt_count == 5'd0)

endmodule

bind csma_cd_backoff_controller_top csmacd_checker u_csmacd_checker (.*);
